// File: hdl/fbc_pkg.sv
package fbc_pkg;

  localparam int NUM_ROUNDS = 8;
  localparam int RND_IDX_W  = $clog2(NUM_ROUNDS);
  localparam int HALF_W     = 32;
  localparam int BLOCK_W    = 2 * HALF_W;
  localparam int KEY_W      = 64;
  localparam int KHALF_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_CIPHER_KEY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_MODE = 2'd1;

  // key halfword sets per round, bit n selects kn
  localparam logic [3:0] LO_SELECT [NUM_ROUNDS] = '{
    4'h3, 4'h5, 4'h9, 4'h6, 4'hC, 4'hA, 4'h2, 4'h1
  };
  localparam logic [3:0] HI_SELECT [NUM_ROUNDS] = '{
    4'h4, 4'h8, 4'h2, 4'h1, 4'h2, 4'h4, 4'h3, 4'h6
  };

  typedef logic [HALF_W-1:0] subkey_t;

  typedef enum logic {
    KS_IDLE,
    KS_RUN
  } ks_state_t;

  // data handed from one round cell to the next
  typedef struct packed {
    logic              valid;
    logic [HALF_W-1:0] left;
    logic [HALF_W-1:0] right;
  } stage_t;

  function automatic logic [KHALF_W-1:0] key_mix(logic [KEY_W-1:0] key, logic [3:0] sel);
    logic [KHALF_W-1:0] acc;
    acc = '0;
    for (int n = 0; n < 4; n++) begin
      if (sel[n]) begin
        acc = acc ^ key[n*KHALF_W +: KHALF_W];
      end
    end
    return acc;
  endfunction

endpackage

// File: hdl/fbc_round_cell.sv
module fbc_round_cell
  import fbc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  stage_t  stage_i,
  input  subkey_t subkey,
  output stage_t  stage_o
);

  logic              valid_r;
  logic [HALF_W-1:0] left_r;
  logic [HALF_W-1:0] right_r;
  logic [HALF_W-1:0] swapped;
  logic [HALF_W-1:0] left_nxt;

  // swap mirrored bit pairs of L wherever the subkey pair differs
  always_comb begin
    for (int j = 0; j < HALF_W; j++) begin
      swapped[j] = (subkey[j] ^ subkey[HALF_W-1-j]) ? stage_i.left[HALF_W-1-j]
                                                    : stage_i.left[j];
    end
  end

  assign left_nxt = swapped ^ stage_i.right;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= stage_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    left_r  <= left_nxt;
    right_r <= stage_i.left;
  end

  assign stage_o = '{valid: valid_r, left: left_r, right: right_r};

endmodule

// File: hdl/fbc_key_sched.sv
module fbc_key_sched
  import fbc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             key_we,
  input  logic [KEY_W-1:0] key_wdata,
  output subkey_t          subkeys [NUM_ROUNDS],
  output logic             busy
);

  ks_state_t            state_r, state_nxt;
  logic [RND_IDX_W-1:0] cnt_r, cnt_nxt;
  logic                 issue;
  logic [KEY_W-1:0]     key_r;
  logic [KHALF_W-1:0]   lo, hi;
  logic [HALF_W-1:0]    p_r;
  logic [RND_IDX_W-1:0] p_idx_r;
  logic                 p_vld_r;
  logic [KHALF_W-1:0]   prod_hi, prod_lo;
  subkey_t              sk_r [NUM_ROUNDS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= KS_IDLE;
      cnt_r   <= '0;
      key_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (key_we) begin
        key_r <= key_wdata;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    issue     = 1'b0;
    case (state_r)
      KS_IDLE: begin
      end
      KS_RUN: begin
        issue   = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == RND_IDX_W'(NUM_ROUNDS - 1)) begin
          state_nxt = KS_IDLE;
        end
      end
      default: begin
        state_nxt = KS_IDLE;
      end
    endcase
    // a new key restarts the sweep from round 0
    if (key_we) begin
      state_nxt = KS_RUN;
      cnt_nxt   = '0;
    end
  end

  assign lo = key_mix(key_r, LO_SELECT[cnt_r]);
  assign hi = key_mix(key_r, HI_SELECT[cnt_r]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= issue && !key_we;
    end
  end

  always_ff @(posedge clk) begin
    p_r     <= HALF_W'(lo) * HALF_W'(hi);
    p_idx_r <= cnt_r;
  end

  assign prod_hi = KHALF_W'(p_r[31:24]) * KHALF_W'(p_r[23:16]);
  assign prod_lo = KHALF_W'(p_r[15:8]) * KHALF_W'(p_r[7:0]);

  // zero key gives zero subkeys, so reset matches the reset key
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ROUNDS; i++) begin
        sk_r[i] <= '0;
      end
    end else if (p_vld_r) begin
      sk_r[p_idx_r] <= {prod_hi, prod_lo};
    end
  end

  assign subkeys = sk_r;
  assign busy    = (state_r == KS_RUN) || p_vld_r;

endmodule

// File: hdl/feistel_block_cipher_64.sv
// Each of the eight round cells registers its stage; out_valid is the valid bit of the last cell.
// Throughput: one block per cycle while busy is low; the round cells form a pipeline fed every such cycle.
// A cipher_key write holds busy high while the shared subkey unit sweeps the eight rounds
// and stores the last subkey; decrypt_mode writes need no sweep and do not raise busy.
// Reset (rst_n, synchronous): clears key, mode, subkeys and all cell valid bits.
// Results are strobed for one cycle and the receiver cannot stall them.
module feistel_block_cipher_64
  import fbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [BLOCK_W-1:0]    in_block_in,
  output logic                  out_valid,
  output logic [BLOCK_W-1:0]    out_block_out,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic    decrypt_r;
  logic    key_we;
  subkey_t subkeys [NUM_ROUNDS];
  stage_t  chain [NUM_ROUNDS+1];

  assign key_we = cfg_we && (cfg_index == CFG_CIPHER_KEY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decrypt_r <= 1'b0;
    end else if (cfg_we && (cfg_index == CFG_DECRYPT_MODE)) begin
      decrypt_r <= cfg_wdata[0];
    end
  end

  fbc_key_sched u_key_sched (
    .clk       (clk),
    .rst_n     (rst_n),
    .key_we    (key_we),
    .key_wdata (cfg_wdata[KEY_W-1:0]),
    .subkeys   (subkeys),
    .busy      (busy)
  );

  assign chain[0] = '{valid: start && !busy,
                      left:  in_block_in[HALF_W-1:0],
                      right: in_block_in[BLOCK_W-1:HALF_W]};

  for (genvar i = 0; i < NUM_ROUNDS; i++) begin : g_cell
    subkey_t cell_sk;
    // decryption runs the rounds in reverse order
    assign cell_sk = decrypt_r ? subkeys[NUM_ROUNDS-1-i] : subkeys[i];

    fbc_round_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .stage_i (chain[i]),
      .subkey  (cell_sk),
      .stage_o (chain[i+1])
    );
  end

  assign out_valid     = chain[NUM_ROUNDS].valid;
  assign out_block_out = {chain[NUM_ROUNDS].left, chain[NUM_ROUNDS].right};

endmodule

// File: hdl/fbc_checker.sv
module fbc_checker
  import fbc_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_valid,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index
);

  // every accepted block comes out after passing through all eight round cells
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##8 out_valid)
    else $error("accepted block not delivered after 8 cycles");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 8))
    else $error("result strobe without matching transfer");

  a_key_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_index == CFG_CIPHER_KEY)) |=> busy)
    else $error("key write did not hold off new blocks");

  a_mode_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_index == CFG_DECRYPT_MODE) && !busy) |=> !busy)
    else $error("mode write raised busy");

endmodule

bind feistel_block_cipher_64 fbc_checker u_fbc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index)
);
